// ===== rtl/assert_macros.svh =====
// Assertion helpers used by hall_commutation_throttle_ramp_core.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("Assertion failed.");

`define ASSERT_NEVER(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(prop)) \
    else $error("Forbidden condition seen.");

`else

`define ASSERT_PROP(lbl, clk, rstn, prop)

`define ASSERT_NEVER(lbl, clk, rstn, prop)

`endif

`endif

// ===== rtl/hctr_pkg.sv =====
package hctr_pkg;

  typedef enum logic [1:0] {
    ReqHall = 2'd0,
    ReqTick = 2'd1,
    ReqCtrl = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    CfgDeadband   = 2'd0,
    CfgRevLimit   = 2'd1,
    CfgRampIntvl  = 2'd2,
    CfgMotionTout = 2'd3
  } cfg_idx_e;

  localparam logic [7:0] DutyStep       = 8'd5;
  localparam logic [7:0] DutyCap        = 8'd250;
  localparam logic [9:0] TimerMax       = 10'd1023;
  localparam logic [2:0] HallAllLow     = 3'd0;
  localparam logic [2:0] HallAllHigh    = 3'd7;
  localparam logic [7:0] DeadbandRst    = 8'd10;
  localparam logic [7:0] RevLimitRst    = 8'd100;
  localparam logic [9:0] RampIntvlRst   = 10'd20;
  localparam logic [9:0] MotionToutRst  = 10'd100;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
  } phase_t;

  typedef struct packed {
    logic [7:0] deadband;
    logic [7:0] rev_limit;
    logic [9:0] ramp_intvl;
    logic [9:0] motion_tout;
  } cfg_t;

  typedef struct packed {
    logic       moving;
    logic       latched_dir;
    logic       dir_hazard;
    logic       hall_fault;
    logic       start_permit;
    logic       first_start;
    logic [7:0] duty;
    logic [9:0] motion_timer;
    logic [9:0] ramp_timer;
    phase_t     ph;
  } st_t;

  localparam phase_t PhaseOff = '{a: 8'd0, b: 8'd0, c: 8'd0};

  localparam st_t StReset = '{
    moving:       1'b0,
    latched_dir:  1'b0,
    dir_hazard:   1'b0,
    hall_fault:   1'b0,
    start_permit: 1'b0,
    first_start:  1'b1,
    duty:         8'd0,
    motion_timer: 10'd0,
    ramp_timer:   10'd0,
    ph:           PhaseOff
  };

  function automatic phase_t commute(logic [2:0] h, logic [7:0] p, logic fwd);
    phase_t r;
    r = PhaseOff;
    if (fwd) begin
      case (h)
        3'd1: begin r.a = p; r.c = p; end
        3'd2: begin r.b = p; r.c = p; end
        3'd3: begin r.a = p; r.b = p; end
        3'd4: r.b = p;
        3'd5: r.c = p;
        default: r.a = p;
      endcase
    end else begin
      case (h)
        3'd1: r.a = p;
        3'd2: r.b = p;
        3'd3: r.c = p;
        3'd4: r.b = p;
        3'd5: r.a = p;
        default: r.c = p;
      endcase
    end
    return r;
  endfunction

endpackage

// ===== rtl/hctr_hall.sv =====
module hctr_hall (
  input  hctr_pkg::st_t  st_i,
  input  logic [2:0]     hall_i,
  input  logic           fwd_i,
  input  logic           brake_i,
  input  logic [7:0]     rev_limit_i,
  output hctr_pkg::st_t  st_o
);

  logic [7:0] p;

  always_comb begin
    p = (st_i.duty > rev_limit_i) ? rev_limit_i : st_i.duty;
    st_o = st_i;
    if (hall_i == hctr_pkg::HallAllLow || hall_i == hctr_pkg::HallAllHigh) begin
      st_o.ph = hctr_pkg::PhaseOff;
      st_o.hall_fault = 1'b1;
    end else if (st_i.moving && (fwd_i != st_i.latched_dir)) begin
      st_o.dir_hazard = 1'b1;
    end else begin
      st_o.motion_timer = '0;
      st_o.moving = 1'b1;
      st_o.latched_dir = fwd_i;
      if (st_i.duty == 8'd0 || !st_i.start_permit || brake_i) begin
        st_o.ph = hctr_pkg::PhaseOff;
      end else if (fwd_i) begin
        st_o.ph = hctr_pkg::commute(hall_i, st_i.duty, 1'b1);
      end else begin
        st_o.ph = hctr_pkg::commute(hall_i, p, 1'b0);
      end
    end
  end

endmodule

// ===== rtl/hctr_step.sv =====
module hctr_step (
  input  hctr_pkg::st_t  st_i,
  input  hctr_pkg::cfg_t cfg_i,
  input  logic [1:0]     req_i,
  input  logic [2:0]     hall_i,
  input  logic [7:0]     throttle_i,
  input  logic           fwd_i,
  input  logic           brake_i,
  input  logic           ext_fault_i,
  output hctr_pkg::st_t  st_o
);

  hctr_pkg::st_t fs;
  hctr_pkg::st_t hall_in;
  hctr_pkg::st_t hall_out;
  hctr_pkg::st_t s;
  hctr_pkg::req_e req;
  logic          kick;
  logic [7:0]    diff;
  logic [7:0]    stp;
  logic [7:0]    sum;
  logic [9:0]    rt_inc;
  logic [9:0]    mt_inc;

  assign req = hctr_pkg::req_e'(req_i);

  always_comb begin
    fs = st_i;
    if (st_i.first_start) begin
      if (throttle_i > cfg_i.deadband) begin
        fs.start_permit = 1'b0;
      end else begin
        fs.start_permit = 1'b1;
        fs.first_start = 1'b0;
      end
    end
    kick = !fs.moving && fs.start_permit && !fs.first_start &&
           (throttle_i >= cfg_i.deadband);
    hall_in = (req == hctr_pkg::ReqHall) ? st_i : fs;
  end

  hctr_hall u_hall (
    .st_i        (hall_in),
    .hall_i      (hall_i),
    .fwd_i       (fwd_i),
    .brake_i     (brake_i),
    .rev_limit_i (cfg_i.rev_limit),
    .st_o        (hall_out)
  );

  always_comb begin
    st_o = st_i;
    s = kick ? hall_out : fs;
    diff = '0;
    stp = '0;
    sum = '0;
    rt_inc = (st_i.ramp_timer < hctr_pkg::TimerMax) ? st_i.ramp_timer + 10'd1
                                                     : st_i.ramp_timer;
    mt_inc = (st_i.motion_timer < hctr_pkg::TimerMax) ? st_i.motion_timer + 10'd1
                                                       : st_i.motion_timer;
    case (req)
      hctr_pkg::ReqHall: begin
        st_o = hall_out;
      end
      hctr_pkg::ReqTick: begin
        st_o.ramp_timer = rt_inc;
        st_o.motion_timer = mt_inc;
        if (mt_inc >= cfg_i.motion_tout) begin
          st_o.motion_timer = '0;
          st_o.moving = 1'b0;
        end
      end
      hctr_pkg::ReqCtrl: begin
        if (ext_fault_i || st_i.hall_fault) begin
          st_o.duty = '0;
          st_o.ph = hctr_pkg::PhaseOff;
        end else begin
          if (s.ramp_timer > cfg_i.ramp_intvl && s.start_permit) begin
            if (s.duty < throttle_i) begin
              s.ramp_timer = '0;
              diff = throttle_i - s.duty;
              stp = (diff >= hctr_pkg::DutyStep) ? hctr_pkg::DutyStep : diff;
              sum = s.duty + stp;
              s.duty = (sum > hctr_pkg::DutyCap) ? hctr_pkg::DutyCap : sum;
            end else if (s.duty > throttle_i) begin
              s.ramp_timer = '0;
              diff = s.duty - throttle_i;
              stp = (diff >= hctr_pkg::DutyStep) ? hctr_pkg::DutyStep : diff;
              s.duty = s.duty - stp;
            end
          end
          if (throttle_i < cfg_i.deadband) begin
            s.duty = '0;
            s.ph = hctr_pkg::PhaseOff;
          end
          if (brake_i) begin
            s.ph = hctr_pkg::PhaseOff;
          end
          if (s.dir_hazard) begin
            if (s.moving) begin
              s.ph = hctr_pkg::PhaseOff;
              s.duty = '0;
            end else begin
              s.dir_hazard = 1'b0;
            end
          end
          st_o = s;
        end
      end
      default: begin
        st_o = st_i;
      end
    endcase
  end

endmodule

// ===== rtl/hall_commutation_throttle_ramp_core.sv =====
// Channel   Direction  Handshake                      Contents
// s_axis    in         s_axis_tvalid / s_axis_tready  one request item
// m_axis    out        m_axis_tvalid / m_axis_tready  one result item
// cfg       in         cfg_valid_i / cfg_ready_o      register index and value
//
// Each request yields one result; one per cycle unless the output stalls.
// The input register and the result register each hold one transaction, so a stalled
// output still lets one more request in before s_axis_tready drops.
// The controller state is updated in the cycle a request moves into the result register.
// Reset clears the state, loads the register defaults and takes effect at once.
`include "assert_macros.svh"

module hall_commutation_throttle_ramp_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // hall[2:0], throttle[10:3], direction_fwd[11], brake[12], external_fault[13].
  input  logic [15:0] s_axis_tdata,
  // req_type[1:0].
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // phase_a_duty[7:0], phase_b_duty[15:8], phase_c_duty[23:16], current_duty[31:24],
  // is_moving[32], hall_fault_latched[33], dir_change_pending[34].
  output logic [39:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [9:0]  cfg_data_i
);

  hctr_pkg::cfg_t cfg_q;
  hctr_pkg::st_t  st_q;
  hctr_pkg::st_t  st_d;
  logic           in_vld_q;
  logic [1:0]     req_q;
  logic [13:0]    in_data_q;
  logic           out_vld_q;
  logic [39:0]    out_data_q;
  logic           adv;

  assign adv           = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign cfg_ready_o   = 1'b1;

  hctr_step u_step (
    .st_i        (st_q),
    .cfg_i       (cfg_q),
    .req_i       (req_q),
    .hall_i      (in_data_q[2:0]),
    .throttle_i  (in_data_q[10:3]),
    .fwd_i       (in_data_q[11]),
    .brake_i     (in_data_q[12]),
    .ext_fault_i (in_data_q[13]),
    .st_o        (st_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.deadband    <= hctr_pkg::DeadbandRst;
      cfg_q.rev_limit   <= hctr_pkg::RevLimitRst;
      cfg_q.ramp_intvl  <= hctr_pkg::RampIntvlRst;
      cfg_q.motion_tout <= hctr_pkg::MotionToutRst;
    end else if (cfg_valid_i) begin
      case (hctr_pkg::cfg_idx_e'(cfg_index_i))
        hctr_pkg::CfgDeadband:   cfg_q.deadband    <= cfg_data_i[7:0];
        hctr_pkg::CfgRevLimit:   cfg_q.rev_limit   <= cfg_data_i[7:0];
        hctr_pkg::CfgRampIntvl:  cfg_q.ramp_intvl  <= cfg_data_i;
        hctr_pkg::CfgMotionTout: cfg_q.motion_tout <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= hctr_pkg::StReset;
    end else if (adv) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      req_q     <= s_axis_tuser;
      in_data_q <= s_axis_tdata[13:0];
    end
    if (adv) begin
      out_data_q <= {5'd0, st_d.dir_hazard, st_d.hall_fault, st_d.moving, st_d.duty,
                     st_d.ph.c, st_d.ph.b, st_d.ph.a};
    end
  end

  `ASSERT_NEVER(a_duty_capped, clk_i, rst_ni, st_q.duty > hctr_pkg::DutyCap)
  `ASSERT_PROP(a_fault_sticky, clk_i, rst_ni, st_q.hall_fault |=> st_q.hall_fault)
  `ASSERT_PROP(a_move_clears_timer, clk_i, rst_ni, $rose(st_q.moving) |-> st_q.motion_timer == '0)
  `ASSERT_PROP(a_stall_holds_input, clk_i, rst_ni, in_vld_q && !adv |=> in_vld_q)

endmodule
